// File: hw/rtl/supq_pkg.sv
// Shared types and constants for the sorted unique priority queue.
// No dependencies; imported by the controller, the datapath and the top level.

package supq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned OpW      = 2;
  localparam int unsigned StW      = 2;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [CntW-1:0]        cnt_t;
  typedef logic [OpW-1:0]         op_t;
  typedef logic [StW-1:0]         status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_POP    = 2'd2;

  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_MISMATCH = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } supq_cmd_t;

endpackage

// File: hw/rtl/supq_ctrl.sv
// Sequencer for the sorted unique priority queue: capture, execute, report.
// Depends on supq_pkg.

module supq_ctrl
  import supq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output supq_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;
  logic accept;

  assign busy_o = (state_q == S_EXEC);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_d = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign cmd_o.capture = accept;
  assign cmd_o.execute = (state_q == S_EXEC);
  assign done_o        = done_q;

`ifndef ASSERT_OFF
  a_accept_execs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.execute)
    else $error("accepted transaction not executed next cycle");

  a_exec_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> done_o && !cmd_o.execute)
    else $error("execute not followed by a single result strobe");

  a_busy_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held for more than one cycle");
`endif

endmodule

// File: hw/rtl/supq_dp.sv
// Datapath: a row of key cells kept in descending order, compared in parallel.
// Depends on supq_pkg; driven by supq_ctrl commands.

module supq_dp
  import supq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  supq_cmd_t cmd_i,
  input  op_t       opcode_i,
  input  key_t      key_i,
  output status_t   status_o,
  output key_t      popped_key_o,
  output cnt_t      count_o
);

  op_t     op_q;
  key_t    key_q;
  key_t    entry_q [Capacity];
  key_t    entry_d [Capacity];
  cnt_t    count_q, count_d;
  status_t status_q, status_d;
  key_t    popped_q, popped_d;

  logic [Capacity-1:0] valid, gt, eq, at_slot, prev_at;
  key_t    up [Capacity];
  key_t    dn [Capacity];
  logic    found, full, empty;
  logic    do_ins, do_rm, do_pop;

  // per-cell compare; sorted order makes gt a thermometer over valid cells
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      valid[i]   = CntW'(i) < count_q;
      gt[i]      = valid[i] && (entry_q[i] > key_q);
      eq[i]      = valid[i] && (entry_q[i] == key_q);
      at_slot[i] = !gt[i];
    end
    prev_at[0] = 1'b0;
    up[0]      = key_q;
    for (int i = 1; i < Capacity; i++) begin
      prev_at[i] = at_slot[i-1];
      up[i]      = entry_q[i-1];
    end
    dn[Capacity-1] = entry_q[Capacity-1];
    for (int i = 0; i < Capacity - 1; i++) begin
      dn[i] = entry_q[i+1];
    end
  end

  assign found  = |eq;
  assign full   = (count_q == CntW'(Capacity));
  assign empty  = (count_q == '0);
  assign do_ins = (op_q == OP_INSERT) && !found && !full;
  assign do_rm  = (op_q == OP_REMOVE) && found;
  assign do_pop = (op_q == OP_POP) && !empty;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      if (do_ins) begin
        entry_d[i] = at_slot[i] ? (prev_at[i] ? up[i] : key_q) : entry_q[i];
      end else if (do_pop) begin
        entry_d[i] = dn[i];
      end else if (do_rm) begin
        entry_d[i] = at_slot[i] ? dn[i] : entry_q[i];
      end else begin
        entry_d[i] = entry_q[i];
      end
    end

    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (do_rm || do_pop) begin
      count_d = count_q - CntW'(1);
    end

    status_d = ST_DONE;
    case (op_q)
      OP_INSERT: begin
        if (found)     status_d = ST_MISMATCH;
        else if (full) status_d = ST_FULL;
      end
      OP_REMOVE: begin
        if (!found) status_d = ST_MISMATCH;
      end
      OP_POP: begin
        if (empty) status_d = ST_UNDERFLOW;
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase

    popped_d = do_pop ? entry_q[0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      key_q <= key_i;
    end
    if (cmd_i.execute) begin
      entry_q  <= entry_d;
      status_q <= status_d;
      popped_q <= popped_d;
    end
  end

  assign status_o     = status_q;
  assign popped_key_o = popped_q;
  assign count_o      = count_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("count exceeds capacity");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.execute |=> $stable(count_q))
    else $error("count changed outside execute");

  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q > CntW'(1)) |-> (entry_q[0] > entry_q[1]))
    else $error("head pair out of descending order");
`endif

endmodule

// File: hw/rtl/sorted_unique_priority_queue_top.sv
// Top level of the sorted unique priority queue.
// Depends on supq_pkg, supq_ctrl and supq_dp.
//
// Usage:
//   Request channel: drive opcode_i (insert, remove, pop largest) and key_i,
//   raise start_i; the transaction is taken at an edge where busy is low.
//   Result channel: done_o is high for exactly one cycle with status_o,
//   popped_key_o and count_o; the receiver must take it in that cycle.
//   Sequence: the request is captured at the accepting edge, the execute
//   cycle then updates the result registers, and the result is on the
//   outputs with done_o once those registers are loaded.
//   Overlap: a new request is not accepted during the execute cycle, in
//   which all 16 key cells compare against the key in parallel and shift
//   in one step. A new request is accepted while the previous result is
//   on the outputs.
//   Reset: the store is empty and count is zero; no clearing pass is needed.
//   The receiver cannot stall; results are never held back.

module sorted_unique_priority_queue_top
  import supq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy,
  input  op_t     opcode_i,
  input  key_t    key_i,
  output logic    done_o,
  output status_t status_o,
  output key_t    popped_key_o,
  output cnt_t    count_o
);

  supq_cmd_t cmd;

  supq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  supq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .opcode_i     (opcode_i),
    .key_i        (key_i),
    .status_o     (status_o),
    .popped_key_o (popped_key_o),
    .count_o      (count_o)
  );

endmodule

// File: dv/supq_scoreboard.sv
// Scoreboard for the sorted unique priority queue: watches the request and
// result channels, predicts each result from its own copy of the store and
// compares them field by field. Depends on supq_pkg.

module supq_scoreboard
  import supq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  op_t         opcode_i,
  input  key_t        key_i,
  input  logic        done_i,
  input  status_t     status_i,
  input  key_t        popped_key_i,
  input  cnt_t        count_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned compared_o
);

  typedef struct packed {
    status_t status;
    key_t    popped;
    cnt_t    count;
  } queue_result_t;

  key_t          held_keys[$];     // model store, largest first
  queue_result_t expected_q[$];
  int unsigned   err_cnt;
  int unsigned   cmp_cnt;
  int unsigned   pend_cnt;

  assign errors_o   = err_cnt;
  assign pending_o  = pend_cnt;
  assign compared_o = cmp_cnt;

  function automatic queue_result_t apply_request(op_t op, key_t k);
    queue_result_t r;
    int unsigned   pos;
    r   = '0;
    pos = 0;
    while (pos < held_keys.size() && held_keys[pos] > k) pos++;
    case (op)
      OP_INSERT: begin
        // duplicate check wins over full check
        if (pos < held_keys.size() && held_keys[pos] == k) r.status = ST_MISMATCH;
        else if (held_keys.size() >= Capacity) r.status = ST_FULL;
        else held_keys.insert(pos, k);
      end
      OP_REMOVE: begin
        if (pos < held_keys.size() && held_keys[pos] == k) held_keys.delete(pos);
        else r.status = ST_MISMATCH;
      end
      OP_POP: begin
        if (held_keys.size() == 0) r.status = ST_UNDERFLOW;
        else r.popped = held_keys.pop_front();
      end
      default: ;  // unused opcode: nothing changes
    endcase
    r.count = cnt_t'(held_keys.size());
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t exp_r;
    if (!rst_ni) begin
      held_keys.delete();
      expected_q.delete();
      err_cnt  = 0;
      cmp_cnt  = 0;
      pend_cnt = 0;
    end else begin
      // check the result first: a transaction taken at this edge is younger
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no transaction outstanding: status %0d count %0d",
                 status_i, count_i);
          err_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          cmp_cnt++;
          if (status_i !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_i);
            err_cnt++;
          end
          if (popped_key_i !== exp_r.popped) begin
            $error("popped_key: expected %0d, got %0d", exp_r.popped, popped_key_i);
            err_cnt++;
          end
          if (count_i !== exp_r.count) begin
            $error("count: expected %0d, got %0d", exp_r.count, count_i);
            err_cnt++;
          end
        end
      end
      if (start_i && !busy_i) expected_q.push_back(apply_request(opcode_i, key_i));
      pend_cnt = expected_q.size();
    end
  end

endmodule

// File: dv/tb_sorted_unique_priority_queue_top.sv
// Testbench top for the sorted unique priority queue: clock, reset, directed
// and random request stimulus with bursty idling, and the final verdict.
// Depends on supq_pkg, sorted_unique_priority_queue_top and supq_scoreboard.

module tb_sorted_unique_priority_queue_top;
  import supq_pkg::*;

  localparam op_t         OP_UNUSED   = 2'd3;
  localparam int unsigned RandomItems = 700;
  localparam int unsigned PoolSize    = 24;

  typedef enum int unsigned {FILL, DRAIN, MIXED} load_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy;
  op_t         opcode_i;
  key_t        key_i;
  logic        done_o;
  status_t     status_o;
  key_t        popped_key_o;
  cnt_t        count_o;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned compared;
  int unsigned op_tally[4];
  key_t        key_pool[PoolSize];

  sorted_unique_priority_queue_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .popped_key_o(popped_key_o),
    .count_o     (count_o)
  );

  supq_scoreboard u_scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .done_i      (done_o),
    .status_i    (status_o),
    .popped_key_i(popped_key_o),
    .count_i     (count_o),
    .errors_o    (mismatches),
    .pending_o   (pending),
    .compared_o  (compared)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // one request transaction; returns at the accepting edge
  task automatic issue(op_t op, key_t k);
    start_i  <= 1'b1;
    opcode_i <= op;
    key_i    <= k;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    op_tally[op]++;
  endtask

  task automatic idle(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // pool keys make duplicates, remove hits and a full store likely
  function automatic key_t pick_key(int unsigned pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return key_pool[$urandom_range(0, PoolSize - 1)];
    return key_t'($urandom);
  endfunction

  function automatic op_t pick_op(load_mode_e mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mode)
      FILL:    return (roll < 70) ? OP_INSERT : (roll < 85) ? OP_REMOVE : OP_POP;
      DRAIN:   return (roll < 20) ? OP_INSERT : (roll < 55) ? OP_REMOVE : OP_POP;
      default: return (roll < 40) ? OP_INSERT : (roll < 70) ? OP_REMOVE :
                      (roll < 99) ? OP_POP : OP_UNUSED;
    endcase
  endfunction

  initial begin
    load_mode_e  mode;
    int unsigned phase_left;
    int unsigned burst_left;
    op_t         op;

    rst_ni     = 1'b0;
    start_i    = 1'b0;
    opcode_i   = OP_INSERT;
    key_i      = '0;
    phase_left = 0;
    burst_left = 0;
    mode       = MIXED;
    foreach (op_tally[i]) op_tally[i] = 0;
    key_pool[0] = 32'sh7fff_ffff;
    key_pool[1] = 32'sh8000_0000;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    key_pool[4] = 32'sd1;
    key_pool[5] = -32'sd2;
    for (int i = 6; i < PoolSize; i++) key_pool[i] = key_t'($urandom);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty-store cases
    issue(OP_POP, 32'sd77);
    issue(OP_REMOVE, 32'sd5);
    // extremes, duplicate, absent remove, unused opcode, pop of the largest
    issue(OP_INSERT, 32'sh7fff_ffff);
    issue(OP_INSERT, 32'sh8000_0000);
    issue(OP_INSERT, 32'sd0);
    issue(OP_INSERT, -32'sd1);
    issue(OP_INSERT, 32'sd0);
    issue(OP_REMOVE, 32'sd5);
    issue(OP_REMOVE, -32'sd1);
    issue(OP_UNUSED, 32'sd0);
    issue(OP_POP, 32'sd0);
    // fill to capacity, then a new key (full) and a duplicate (duplicate wins)
    for (int i = 0; i < 14; i++) issue(OP_INSERT, key_t'(100 + 7 * i));
    issue(OP_INSERT, 32'sd12345);
    issue(OP_INSERT, 32'sd0);
    drain();

    for (int i = 0; i < RandomItems; i++) begin
      if (phase_left == 0) begin
        mode       = load_mode_e'($urandom_range(0, 2));
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      op = pick_op(mode);
      issue(op, pick_key(op == OP_REMOVE ? 80 : 60));
      if (i == RandomItems / 2) drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
      end else begin
        burst_left--;
      end
    end

    drain();
    repeat (6) @(posedge clk_i);

    $display("Covered %0d inserts, %0d removes, %0d pops and %0d unused-opcode requests,",
             op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_POP], op_tally[OP_UNUSED]);
    $display("with fill/drain phases reaching full and empty; %0d results compared.",
             compared);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/supq_pkg.sv
hw/rtl/supq_ctrl.sv
hw/rtl/supq_dp.sv
hw/rtl/sorted_unique_priority_queue_top.sv
dv/supq_scoreboard.sv
dv/tb_sorted_unique_priority_queue_top.sv
